/* hw/rtl/ipfl_pkg.sv */
// Shared constants for the instrument patch fallback lookup block.
`timescale 1ns / 1ps
`default_nettype none
package ipfl_pkg;
  localparam int unsigned MaxEntries = 256;
  localparam int unsigned AddrW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned SlotW      = 8;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned BankW      = 32;
  localparam int unsigned ProgW      = 7;
  localparam int unsigned LevelW     = 2;
  localparam int unsigned NumLevels  = 4;
  localparam int unsigned EntryW     = BankW + ProgW;
  localparam int unsigned ScanW      =
      ($clog2(MaxEntries + 1) > CfgW) ? $clog2(MaxEntries + 1) : CfgW;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 16;

  localparam logic [BankW-1:0] MaskBank = 32'h8000_7f00;
  localparam logic [BankW-1:0] MaskDrum = 32'h8000_0000;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdLookup = 1'b1;
endpackage
`default_nettype wire

/* hw/rtl/instrument_patch_fallback_lookup_core.sv */
// Top level: instrument table with a four-level fallback lookup scan.
// A write transfer stores one entry and produces no result.
// A lookup reads the n active entries (n is the clamped entry count) one per cycle.
// Its result passes the RAM read, the compare and the StResult state into the output register,
// and the next transfer is taken only once that register is loaded; output stalls hold it off.
// Reset clears the entry count and control state; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module instrument_patch_fallback_lookup_core
  import ipfl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,      // entry_count
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,     // slot, bank_word, program_number
  input  wire logic                s_axis_tuser,     // command
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,     // patch_index, match_level
  output logic                     m_axis_tuser      // found
);
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StResult
  } state_e;

  state_e               state_q;
  logic [CfgW-1:0]      entry_count_q;
  logic [ScanW-1:0]     limit_q;
  logic [ScanW-1:0]     issue_q;
  logic                 cmp_vld_q;
  logic [AddrW-1:0]     cmp_idx_q;
  logic [BankW-1:0]     req_bank_q;
  logic [ProgW-1:0]     req_prog_q;
  logic [NumLevels-1:0] hit_q;
  logic [AddrW-1:0]     hit_idx_q [NumLevels];
  logic                 out_vld_q;
  logic                 out_found_q;
  logic [IdxW-1:0]      out_idx_q;
  logic [LevelW-1:0]    out_level_q;

  logic [SlotW-1:0]     in_slot;
  logic [BankW-1:0]     in_bank;
  logic [ProgW-1:0]     in_prog;
  logic                 in_fire;
  logic                 ram_we;
  logic                 ram_re;
  logic [EntryW-1:0]    ram_rdata;
  logic [BankW-1:0]     ent_bank;
  logic [ProgW-1:0]     ent_prog;
  logic [NumLevels-1:0] match;
  logic                 prog_eq;
  logic                 scan_done;
  logic                 out_load;
  logic [ScanW-1:0]     count_ext;
  logic [ScanW-1:0]     limit_d;
  logic                 res_found;
  logic [AddrW-1:0]     res_idx;
  logic [LevelW-1:0]    res_level;

  assign in_slot = s_axis_tdata[SlotW-1:0];
  assign in_bank = s_axis_tdata[SlotW+BankW-1:SlotW];
  assign in_prog = s_axis_tdata[SlotW+BankW+ProgW-1:SlotW+BankW];

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign ram_we = in_fire && (s_axis_tuser == CmdWrite) &&
                  (ScanW'(in_slot) < ScanW'(MaxEntries));
  assign ram_re = (state_q == StScan) && (issue_q < limit_q);

  ipfl_ram #(
    .Width(EntryW),
    .Depth(MaxEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AddrW'(in_slot)),
    .wdata_i({in_prog, in_bank}),
    .re_i   (ram_re),
    .raddr_i(issue_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign ent_bank = ram_rdata[BankW-1:0];
  assign ent_prog = ram_rdata[EntryW-1:BankW];
  assign prog_eq  = (ent_prog == req_prog_q);

  always_comb begin
    match[0] = (ent_bank == req_bank_q) && prog_eq;
    match[1] = (((ent_bank ^ req_bank_q) & MaskBank) == '0) && prog_eq;
    match[2] = (((ent_bank ^ req_bank_q) & MaskDrum) == '0) && prog_eq;
    match[3] = ((req_bank_q & MaskDrum) != '0) && ((ent_bank & MaskDrum) != '0);
  end

  assign count_ext = ScanW'(entry_count_q);
  assign limit_d   = (count_ext > ScanW'(MaxEntries)) ? ScanW'(MaxEntries) : count_ext;
  assign scan_done = (issue_q >= limit_q) && !cmp_vld_q;
  assign out_load  = (state_q == StResult) && (!out_vld_q || m_axis_tready);

  always_comb begin
    res_found = 1'b0;
    res_idx   = '0;
    res_level = '0;
    for (int k = NumLevels - 1; k >= 0; k--) begin
      if (hit_q[k]) begin
        res_found = 1'b1;
        res_idx   = hit_idx_q[k];
        res_level = LevelW'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      entry_count_q <= '0;
      limit_q       <= '0;
      issue_q       <= '0;
      cmp_vld_q     <= 1'b0;
      hit_q         <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      cmp_vld_q <= ram_re;
      case (state_q)
        StIdle: begin
          if (in_fire && (s_axis_tuser == CmdLookup)) begin
            limit_q <= limit_d;
            issue_q <= '0;
            hit_q   <= '0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (ram_re) begin
            issue_q <= issue_q + 1'b1;
          end
          if (cmp_vld_q) begin
            for (int k = 0; k < NumLevels; k++) begin
              if (!hit_q[k] && match[k]) begin
                hit_q[k] <= 1'b1;
              end
            end
          end
          if (scan_done) begin
            state_q <= StResult;
          end
        end
        StResult: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_bank_q <= in_bank;
      req_prog_q <= in_prog;
    end
    cmp_idx_q <= issue_q[AddrW-1:0];
    if ((state_q == StScan) && cmp_vld_q) begin
      for (int k = 0; k < NumLevels; k++) begin
        if (!hit_q[k] && match[k]) begin
          hit_idx_q[k] <= cmp_idx_q;
        end
      end
    end
    if (out_load) begin
      out_found_q <= res_found;
      out_idx_q   <= IdxW'(res_idx);
      out_level_q <= res_level;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {{(OutDataW - IdxW - LevelW){1'b0}}, out_level_q, out_idx_q};
endmodule
`default_nettype wire

/* hw/rtl/ipfl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module ipfl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  wire logic [Width-1:0]                  wdata_i,
  input  wire logic                              re_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic      [Width-1:0]                  rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire
